// ===== sv/rhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_pkg
// shared widths, codes and the beat that travels down the divider cell row
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueNumW = 17;  // up to 360*255 + 60*255 fits
  localparam int unsigned SatNumW = 16;  // 255*255
  localparam int unsigned QuoW    = 9;   // hue quotient below 360

  localparam logic [ChanW-1:0] HueCap    = 8'd179;
  localparam logic [ChanW-1:0] FullScale = 8'd255;

  // which channel holds the maximum, and whether red wraps round
  typedef enum logic [3:0] {
    SecRed     = 4'b0001,
    SecRedWrap = 4'b0010,
    SecGreen   = 4'b0100,
    SecBlue    = 4'b1000
  } sector_e;

  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [QuoW-1:0]    hue_quo;
    logic [SatNumW-1:0] sat_rem;
    logic [QuoW-1:0]    sat_quo;
    logic [ChanW-1:0]   hi;
    logic [ChanW-1:0]   delta;
  } div_t;

endpackage

// ===== sv/rhp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_if
// valid/ready channels for rgb pixels in and hsv pixels out
// ----------------------------------------------------------------------------
interface rhp_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhp_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== sv/rgb_to_hsv_pixel_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit
// 8-bit rgb to 8-bit hsv, hue in half degrees, through a row of divider cells
// ----------------------------------------------------------------------------
//
//   port   | dir | payload                          | beat
//   -------+-----+----------------------------------+---------------------
//   pix_i  | in  | red, green, blue (8b each)       | one rgb pixel
//   hsv_o  | out | hue, saturation, brightness (8b) | one hsv pixel
//
// one pixel per clock while the output is taken; from accepted beat to output
// beat a pixel passes 2 prep stages, 9 divider cells and 1 output register
// the whole row advances together: it moves whenever the output register is
// empty or being taken, so an output stall holds every stage in place
// reset clears the valid bits only; payload registers are not reset
//
module rgb_to_hsv_pixel_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhp_rgb_if.sink   pix_i,
  rhp_hsv_if.source hsv_o
);

  localparam int unsigned NCells = rhp_pkg::QuoW;

  // global advance of the row
  logic en;

  logic          cv [NCells+1];
  rhp_pkg::div_t cd [NCells+1];

  // output register
  logic                       out_valid_q;
  logic [rhp_pkg::ChanW-1:0]  hue_d, hue_q, sat_d, sat_q, bri_q;
  logic [rhp_pkg::ChanW-1:0]  half_hue;

  assign en          = !out_valid_q || hsv_o.ready;
  assign pix_i.ready = en;

  // max, min, sector and the two dividends
  rhp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (cv[0]),
    .data_o  (cd[0])
  );

  // cell k settles quotient bit QuoW-1-k of both hue and saturation
  for (genvar k = 0; k < NCells; k++) begin : g_cell
    rhp_div_cell #(
      .Shift (NCells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .data_o  (cd[k+1])
    );
  end

  // final touch: halve and cap the hue, cap saturation, black and grey cases
  always_comb begin
    half_hue = cd[NCells].hue_quo[rhp_pkg::QuoW-1:1];
    if (half_hue > rhp_pkg::HueCap) begin
      half_hue = rhp_pkg::HueCap;
    end
    if (cd[NCells].sat_quo[rhp_pkg::QuoW-1]) begin
      sat_d = rhp_pkg::FullScale;
    end else begin
      sat_d = cd[NCells].sat_quo[rhp_pkg::ChanW-1:0];
    end
    hue_d = half_hue;
    // black pixel: no hue, no saturation
    if (cd[NCells].hi == '0) begin
      sat_d = '0;
      hue_d = '0;
    end
    // grey pixel: no hue
    if (cd[NCells].delta == '0) begin
      hue_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cv[NCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= cd[NCells].hi;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;

`ifndef ASSERT_OFF
  // hue in half degrees never leaves its range
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue <= rhp_pkg::HueCap))
    else $error("hue above cap");

  // black pixel carries neither hue nor saturation
  a_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && (hsv_o.brightness == '0)) |->
      ((hsv_o.hue == '0) && (hsv_o.saturation == '0)))
    else $error("black pixel with hue or saturation");

  // zero saturation only comes from a grey pixel, which has no hue
  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && (hsv_o.saturation == '0)) |-> (hsv_o.hue == '0))
    else $error("unsaturated pixel with hue");

  // a held output beat keeps the row frozen, checked at the last cell, its valid included
  a_row_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && !hsv_o.ready) |=> $stable(cv[NCells]) && $stable(cd[NCells]))
    else $error("divider row moved during output stall");
`endif

endmodule

// ===== sv/rhp_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_prep
// two stages: max/min/sector, then the hue and saturation dividends
// ----------------------------------------------------------------------------
module rhp_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [rhp_pkg::ChanW-1:0] red_i,
  input  logic [rhp_pkg::ChanW-1:0] green_i,
  input  logic [rhp_pkg::ChanW-1:0] blue_i,
  output logic                     valid_o,
  output rhp_pkg::div_t            data_o
);

  // stage a
  logic [rhp_pkg::ChanW-1:0] hi_d, lo_d, hi_q, delta_q;
  logic signed [8:0]         diff_d, diff_q;
  rhp_pkg::sector_e          sec_d, sec_q;
  logic                      va_q;

  // stage b
  logic signed [17:0]          off_s, prod_s, num_s;
  rhp_pkg::div_t               b_d, b_q;
  logic                        vb_q;

  always_comb begin
    hi_d = (red_i > green_i) ? red_i : green_i;
    lo_d = (red_i > green_i) ? green_i : red_i;
    if (blue_i > hi_d) begin
      hi_d = blue_i;
    end
    if (blue_i < lo_d) begin
      lo_d = blue_i;
    end
    // red wins ties, then green
    if (red_i == hi_d) begin
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
      sec_d  = (green_i >= blue_i) ? rhp_pkg::SecRed : rhp_pkg::SecRedWrap;
    end else if (green_i == hi_d) begin
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
      sec_d  = rhp_pkg::SecGreen;
    end else begin
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
      sec_d  = rhp_pkg::SecBlue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q    <= hi_d;
      delta_q <= hi_d - lo_d;
      diff_q  <= diff_d;
      sec_q   <= sec_d;
      b_q     <= b_d;
    end
  end

  always_comb begin
    unique case (sec_q)
      rhp_pkg::SecRed:     off_s = 18'sd0;
      rhp_pkg::SecRedWrap: off_s = $signed(18'(delta_q)) * 18'sd360;
      rhp_pkg::SecGreen:   off_s = $signed(18'(delta_q)) * 18'sd120;
      rhp_pkg::SecBlue:    off_s = $signed(18'(delta_q)) * 18'sd240;
      default:             off_s = 18'sd0;
    endcase
    prod_s        = 18'(diff_q) * 18'sd60;
    num_s         = off_s + prod_s;
    b_d.hue_rem   = num_s[rhp_pkg::HueNumW-1:0];
    b_d.hue_quo   = '0;
    // 255 * delta
    b_d.sat_rem   = {delta_q, 8'h00} - rhp_pkg::SatNumW'(delta_q);
    b_d.sat_quo   = '0;
    b_d.hi        = hi_q;
    b_d.delta     = delta_q;
  end

  assign valid_o = vb_q;
  assign data_o  = b_q;

endmodule

// ===== sv/rhp_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_div_cell
// one restoring step for both dividers, one quotient bit each
// ----------------------------------------------------------------------------
module rhp_div_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rhp_pkg::div_t data_i,
  output logic          valid_o,
  output rhp_pkg::div_t data_o
);

  logic [rhp_pkg::HueNumW-1:0] hue_den;
  logic [rhp_pkg::SatNumW-1:0] sat_den;
  rhp_pkg::div_t               data_d, data_q;
  logic                        valid_q;

  always_comb begin
    data_d  = data_i;
    hue_den = rhp_pkg::HueNumW'(data_i.delta) << Shift;
    sat_den = rhp_pkg::SatNumW'(data_i.hi) << Shift;
    if (data_i.hue_rem >= hue_den) begin
      data_d.hue_rem = data_i.hue_rem - hue_den;
      data_d.hue_quo = {data_i.hue_quo[rhp_pkg::QuoW-2:0], 1'b1};
    end else begin
      data_d.hue_quo = {data_i.hue_quo[rhp_pkg::QuoW-2:0], 1'b0};
    end
    if (data_i.sat_rem >= sat_den) begin
      data_d.sat_rem = data_i.sat_rem - sat_den;
      data_d.sat_quo = {data_i.sat_quo[rhp_pkg::QuoW-2:0], 1'b1};
    end else begin
      data_d.sat_quo = {data_i.sat_quo[rhp_pkg::QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for rgb_to_hsv_pixel_unit: a queue-fed driver offers rgb
// beats with random gaps, a monitor predicts each hsv beat at input acceptance
// and compares it field by field with what comes out, in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned N_RANDOM    = 1450;
  localparam int unsigned LONG_HOLD   = 200;    // output hold-off, in cycles
  localparam int unsigned HOLD_AT     = 400;    // output beat count that triggers it
  localparam int unsigned CALM_FIRST  = 900;    // output beats with no receiver stalls
  localparam int unsigned CALM_LAST   = 1100;
  localparam int unsigned DRAIN_EVERY = 300;    // random pixels between drain pauses
  localparam int unsigned TAIL_CYCLES = 40;     // extra wait once nothing is in flight
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_MAX   = 40;

  typedef struct packed {
    logic [rhp_pkg::ChanW-1:0] red;
    logic [rhp_pkg::ChanW-1:0] green;
    logic [rhp_pkg::ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [rhp_pkg::ChanW-1:0] hue;
    logic [rhp_pkg::ChanW-1:0] saturation;
    logic [rhp_pkg::ChanW-1:0] brightness;
  } hsv_t;

  typedef struct {
    rgb_t px;
    int   gap;     // idle cycles before the beat is offered
    bit   drain;   // hold the beat back until every hsv beat is home
  } pix_job_t;

  typedef struct {
    rgb_t px;
    hsv_t hsv;
  } hsv_want_t;

  logic clk;
  logic rst_n;

  rhp_rgb_if pix_if ();
  rhp_hsv_if hsv_if ();

  rgb_to_hsv_pixel_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .hsv_o  (hsv_if)
  );

  pix_job_t  pix_pending[$];
  hsv_want_t hsv_expected[$];

  int unsigned n_jobs;
  int unsigned pix_in_count;
  int unsigned hsv_out_count;
  int unsigned in_flight;
  int unsigned fault_count;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // predictor: 8-bit hsv with hue in half degrees, exact integer quotients
  // --------------------------------------------------------------------------
  function automatic hsv_t hsv_of(rgb_t px);
    int   r, g, b, top, bottom, span, num, sat, half;
    hsv_t o;
    r = px.red;
    g = px.green;
    b = px.blue;
    top    = (r > g) ? r : g;
    bottom = (r > g) ? g : r;
    if (b > top) top = b;
    if (b < bottom) bottom = b;
    span = top - bottom;
    o.brightness = top[rhp_pkg::ChanW-1:0];
    o.saturation = '0;
    o.hue        = '0;
    // black pixel: hue and saturation both stay at zero
    if (top != 0) begin
      sat = (int'(rhp_pkg::FullScale) * span) / top;
      if (sat > int'(rhp_pkg::FullScale)) sat = int'(rhp_pkg::FullScale);
      o.saturation = sat[rhp_pkg::ChanW-1:0];
      // grey pixel keeps hue at zero
      if (span != 0) begin
        // red wins ties, then green; red with green below blue wraps by 360
        if (r == top) begin
          if (g >= b) num = 60 * (g - b);
          else        num = 360 * span + 60 * (g - b);
        end else if (g == top) begin
          num = 120 * span + 60 * (b - r);
        end else begin
          num = 240 * span + 60 * (r - g);
        end
        half = (num / span) / 2;
        if (half > int'(rhp_pkg::HueCap)) half = int'(rhp_pkg::HueCap);
        o.hue = half[rhp_pkg::ChanW-1:0];
      end
    end
    return o;
  endfunction

  task automatic log_fault(string msg);
    if (fault_count < PRINT_MAX) $display("[%0t] %s", $time, msg);
    fault_count++;
  endtask

  // idle stretch lengths: mostly short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic logic [rhp_pkg::ChanW-1:0] near(logic [rhp_pkg::ChanW-1:0] base);
    int v;
    v = int'(base) + $urandom_range(4) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[rhp_pkg::ChanW-1:0];
  endfunction

  function automatic logic [rhp_pkg::ChanW-1:0] corner_chan();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // random pixel mix: plain noise, greys, near-greys, tied channel pairs, tiny and corner values
  function automatic rgb_t random_pixel();
    rgb_t                      px;
    logic [rhp_pkg::ChanW-1:0] v;
    px = rgb_t'((3 * rhp_pkg::ChanW)'($urandom));
    v  = rhp_pkg::ChanW'($urandom);
    case ($urandom_range(9))
      5: px = '{red: v, green: v, blue: v};
      6: begin
        case ($urandom_range(2))
          0:       begin px.red = v;   px.green = v; end
          1:       begin px.red = v;   px.blue  = v; end
          default: begin px.green = v; px.blue  = v; end
        endcase
      end
      7: px = '{red:   rhp_pkg::ChanW'($urandom_range(3)),
                green: rhp_pkg::ChanW'($urandom_range(3)),
                blue:  rhp_pkg::ChanW'($urandom_range(3))};
      8: px = '{red: corner_chan(), green: corner_chan(), blue: corner_chan()};
      9: px = '{red: near(v), green: near(v), blue: near(v)};
      default: ;
    endcase
    return px;
  endfunction

  task automatic add_pixel(int r, int g, int b, int gap, bit drain);
    pix_job_t job;
    job.px    = '{red: r[rhp_pkg::ChanW-1:0], green: g[rhp_pkg::ChanW-1:0],
                  blue: b[rhp_pkg::ChanW-1:0]};
    job.gap   = gap;
    job.drain = drain;
    pix_pending = {pix_pending, job};
    n_jobs++;
  endtask

  // --------------------------------------------------------------------------
  // clock and reset; every block input is known from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    pix_if.valid   = 1'b0;
    pix_if.red     = '0;
    pix_if.green   = '0;
    pix_if.blue    = '0;
    hsv_if.ready   = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
      end
    join_none
  end

  // --------------------------------------------------------------------------
  // driver: pops the pending queue, honours gaps and drain pauses, and only
  // changes the beat once the current one has gone (valid low or ready high)
  // --------------------------------------------------------------------------
  pix_job_t next_job;
  bit       job_staged;
  int       gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      job_staged   = 1'b0;
      gap_left     = 0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (!job_staged && pix_pending.size() != 0) begin
        next_job   = pix_pending.pop_front();
        job_staged = 1'b1;
        gap_left   = next_job.gap;
      end
      if (job_staged && gap_left > 0) begin
        gap_left--;
        pix_if.valid <= 1'b0;
      end else if (job_staged && next_job.drain && (pix_if.valid || in_flight != 0)) begin
        // drain pause: nothing in the pipe before this beat goes in
        pix_if.valid <= 1'b0;
      end else if (job_staged) begin
        pix_if.valid <= 1'b1;
        pix_if.red   <= next_job.px.red;
        pix_if.green <= next_job.px.green;
        pix_if.blue  <= next_job.px.blue;
        job_staged   = 1'b0;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, a calm stretch with ready held high, and one long
  // hold-off so the row fills up and backs onto the input side
  // --------------------------------------------------------------------------
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hsv_if.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else if (!hold_done && hsv_out_count >= HOLD_AT) begin
      hold_done    = 1'b1;
      hold_left    = LONG_HOLD - 1;
      hsv_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hsv_if.ready <= 1'b0;
    end else if (hsv_out_count >= CALM_FIRST && hsv_out_count < CALM_LAST) begin
      hsv_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hsv_if.ready <= 1'b0;
    end else begin
      hsv_if.ready <= 1'b1;
      if ($urandom_range(99) < 25) stall_left = idle_len();
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on input acceptance, checks on output acceptance; both
  // sides in one block so the order within an edge is fixed
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    rgb_t      px;
    hsv_t      got;
    hsv_want_t want;
    if (!rst_n) begin
      pix_in_count  <= 0;
      hsv_out_count <= 0;
      in_flight     <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        px = '{red: pix_if.red, green: pix_if.green, blue: pix_if.blue};
        want.px  = px;
        want.hsv = hsv_of(px);
        hsv_expected = {hsv_expected, want};
        pix_in_count <= pix_in_count + 1;
      end
      if (hsv_if.valid && hsv_if.ready) begin
        got = '{hue: hsv_if.hue, saturation: hsv_if.saturation,
                brightness: hsv_if.brightness};
        if (hsv_expected.size() == 0) begin
          log_fault($sformatf("hsv beat (%0d,%0d,%0d) with no pixel waiting",
                              got.hue, got.saturation, got.brightness));
        end else begin
          want = hsv_expected.pop_front();
          if (got.hue !== want.hsv.hue)
            log_fault($sformatf("hue for rgb(%0d,%0d,%0d): got %0d, want %0d",
                                want.px.red, want.px.green, want.px.blue,
                                got.hue, want.hsv.hue));
          if (got.saturation !== want.hsv.saturation)
            log_fault($sformatf("saturation for rgb(%0d,%0d,%0d): got %0d, want %0d",
                                want.px.red, want.px.green, want.px.blue,
                                got.saturation, want.hsv.saturation));
          if (got.brightness !== want.hsv.brightness)
            log_fault($sformatf("brightness for rgb(%0d,%0d,%0d): got %0d, want %0d",
                                want.px.red, want.px.green, want.px.blue,
                                got.brightness, want.hsv.brightness));
        end
        hsv_out_count <= hsv_out_count + 1;
      end
      in_flight <= hsv_expected.size();
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("rgb_to_hsv_pixel_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: directed corners first, then random pixels; then wait for the
  // last hsv beat and report
  // --------------------------------------------------------------------------
  initial begin
    pix_job_t job;
    int       n;
    n_jobs      = 0;
    fault_count = 0;
    cycle_count = 0;

    // black, white, primaries and field extremes
    add_pixel(0, 0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 0, 1'b0);
    add_pixel(255, 0, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 1, 1'b0);
    add_pixel(0, 0, 255, 0, 1'b0);
    add_pixel(1, 0, 0, 0, 1'b0);
    add_pixel(128, 128, 128, 2, 1'b0);   // grey
    add_pixel(1, 1, 1, 0, 1'b0);
    // ties for the maximum
    add_pixel(255, 255, 0, 0, 1'b0);
    add_pixel(255, 0, 255, 0, 1'b0);
    add_pixel(0, 255, 255, 0, 1'b0);
    add_pixel(200, 200, 17, 0, 1'b1);    // drain pause before this one
    // red maximum with green below blue, wrapping round
    add_pixel(255, 0, 1, 0, 1'b0);
    add_pixel(1, 0, 1, 0, 1'b0);
    add_pixel(200, 10, 199, 3, 1'b0);
    // each sector, mostly away from the ties
    add_pixel(200, 10, 20, 0, 1'b0);
    add_pixel(10, 200, 20, 0, 1'b0);
    add_pixel(20, 10, 200, 0, 1'b0);
    add_pixel(254, 255, 253, 0, 1'b0);
    add_pixel(255, 254, 255, 0, 1'b0);
    add_pixel(1, 0, 255, 0, 1'b0);
    add_pixel(170, 85, 0, 0, 1'b0);

    for (n = 0; n < N_RANDOM; n++) begin
      job.px    = random_pixel();
      // an unbroken run in the middle, random gaps everywhere else
      job.gap   = (n >= 600 && n < 800) ? 0 : pick_gap();
      job.drain = (n % DRAIN_EVERY) == 0;
      pix_pending = {pix_pending, job};
      n_jobs++;
    end

    while (pix_in_count != n_jobs) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (hsv_expected.size() != 0)
      log_fault($sformatf("%0d hsv beats never arrived", hsv_expected.size()));
    $display("%0d pixels converted and checked in %0d cycles: corners, ties, greys,",
             pix_in_count, cycle_count);
    $display("red wrap-round, random gaps, drain pauses and a %0d-cycle output hold-off",
             LONG_HOLD);
    if (fault_count == 0) begin
      $display("rgb_to_hsv_pixel_unit: match");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("rgb_to_hsv_pixel_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rhp_pkg.sv
sv/rhp_if.sv
sv/rhp_prep.sv
sv/rhp_div_cell.sv
sv/rgb_to_hsv_pixel_unit.sv
sim/testbench.sv
